@@ rtl/core/srcc_pkg.sv @@
`timescale 1ns / 1ps

package srcc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // byte positions inside a six-byte frame
    localparam logic [2:0] POS_W0_HI  = 3'd0;
    localparam logic [2:0] POS_W0_LO  = 3'd1;
    localparam logic [2:0] POS_W0_CRC = 3'd2;
    localparam logic [2:0] POS_W1_HI  = 3'd3;
    localparam logic [2:0] POS_W1_LO  = 3'd4;
    localparam logic [2:0] POS_W1_CRC = 3'd5;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_W0_BAD = 2'd1;
    localparam logic [1:0] STATUS_W1_BAD = 2'd2;

    localparam int unsigned OUT_TDATA_W = 40;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] voc_word;
        logic [15:0] co2_word;
    } t_result;

    // one byte through crc-8, msb first, bit by bit
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 8'd0) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/core/srcc_frame_tracker.sv @@
`timescale 1ns / 1ps

module srcc_frame_tracker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_frame_start,
    output logic             o_res_valid,
    output srcc_pkg::t_result o_result
);

    logic [2:0]  r_pos;
    logic [7:0]  r_crc;
    logic [15:0] r_word0;
    logic [15:0] r_word1;
    logic        r_word0_bad;

    logic [2:0]  n_pos;
    logic [7:0]  n_crc;
    logic [15:0] n_word0;
    logic [15:0] n_word1;
    logic        n_word0_bad;
    logic [2:0]  pos;

    always_comb begin
        pos = i_frame_start ? srcc_pkg::POS_W0_HI : r_pos;
        // positions past the end of a frame restart it
        if (pos inside {3'd6, 3'd7}) begin
            pos = srcc_pkg::POS_W0_HI;
        end

        n_crc       = r_crc;
        n_word0     = r_word0;
        n_word1     = r_word1;
        n_word0_bad = r_word0_bad;
        o_res_valid = 1'b0;
        o_result.co2_word = r_word0;
        o_result.voc_word = r_word1;
        o_result.status   = srcc_pkg::STATUS_OK;

        case (pos)
            srcc_pkg::POS_W0_HI: begin
                n_crc   = srcc_pkg::crc8_byte(srcc_pkg::CRC_INIT, i_rx_byte);
                n_word0 = {i_rx_byte, 8'h00};
            end
            srcc_pkg::POS_W0_LO: begin
                n_crc   = srcc_pkg::crc8_byte(r_crc, i_rx_byte);
                n_word0 = {r_word0[15:8], i_rx_byte};
            end
            srcc_pkg::POS_W0_CRC: begin
                n_word0_bad = (r_crc != i_rx_byte);
                n_crc       = srcc_pkg::CRC_INIT;
            end
            srcc_pkg::POS_W1_HI: begin
                n_crc   = srcc_pkg::crc8_byte(srcc_pkg::CRC_INIT, i_rx_byte);
                n_word1 = {i_rx_byte, 8'h00};
            end
            srcc_pkg::POS_W1_LO: begin
                n_crc   = srcc_pkg::crc8_byte(r_crc, i_rx_byte);
                n_word1 = {r_word1[15:8], i_rx_byte};
            end
            default: begin
                o_res_valid = 1'b1;
                if (r_word0_bad) begin
                    o_result.status = srcc_pkg::STATUS_W0_BAD;
                end else if (r_crc != i_rx_byte) begin
                    o_result.status = srcc_pkg::STATUS_W1_BAD;
                end
                n_crc = srcc_pkg::CRC_INIT;
            end
        endcase

        n_pos = (pos == srcc_pkg::POS_W1_CRC) ? srcc_pkg::POS_W0_HI : pos + 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= srcc_pkg::POS_W0_HI;
            r_crc       <= srcc_pkg::CRC_INIT;
            r_word0     <= 16'd0;
            r_word1     <= 16'd0;
            r_word0_bad <= 1'b0;
        end else if (i_fire) begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_word0     <= n_word0;
            r_word1     <= n_word1;
            r_word0_bad <= n_word0_bad;
        end
    end

endmodule

@@ rtl/core/srcc_out_stage.sv @@
`timescale 1ns / 1ps

module srcc_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  srcc_pkg::t_result i_result,
    input  logic             i_m_tready,
    output logic             o_can_take,
    output logic             o_m_tvalid,
    output srcc_pkg::t_result o_result
);

    logic             r_valid;
    srcc_pkg::t_result r_result;

    // slot frees in the same cycle the held result is taken
    assign o_can_take = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ rtl/core/sensor_reply_crc_checker.sv @@
`timescale 1ns / 1ps
// one reply byte per transaction, a new byte can be taken every cycle while the output register is free or being read
// frame state and crc update on the accepting edge; the result of a frame's
// sixth byte shows on the output in the following cycle, held in a single output register
// throughput is one byte per cycle while the output side keeps up
// synchronous active-low reset: position 0, crc 0xff, words and error flag cleared
module sensor_reply_crc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_s_tuser,   // [0] frame_start
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // [15:0] co2_word, [31:16] voc_word, [33:32] status
);

    logic              fire;
    logic              res_valid;
    logic              can_take;
    srcc_pkg::t_result res;
    srcc_pkg::t_result held;

    assign o_s_tready = can_take;
    assign fire       = i_s_tvalid && can_take;

    srcc_frame_tracker u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_rx_byte     (i_s_tdata),
        .i_frame_start (i_s_tuser),
        .o_res_valid   (res_valid),
        .o_result      (res)
    );

    srcc_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && res_valid),
        .i_result   (res),
        .i_m_tready (i_m_tready),
        .o_can_take (can_take),
        .o_m_tvalid (o_m_tvalid),
        .o_result   (held)
    );

    assign o_m_tdata = {{(srcc_pkg::OUT_TDATA_W - $bits(srcc_pkg::t_result)){1'b0}}, held};

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int N_ITEMS        = 1600;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT    = 3000;

    // predicted frame state plus the replies still owed by the block
    class reply_tracker;
        logic [2:0]        pos;
        logic [7:0]        crc;
        logic [15:0]       w0;
        logic [15:0]       w1;
        logic              w0_bad;
        srcc_pkg::t_result expected_replies[$];
        int                mismatch_count;

        function new();
            pos            = srcc_pkg::POS_W0_HI;
            crc            = srcc_pkg::CRC_INIT;
            w0             = '0;
            w1             = '0;
            w0_bad         = 1'b0;
            mismatch_count = 0;
        endfunction

        // bit-serial crc-8, one data bit shifted in per step
        static function logic [7:0] crc_update(logic [7:0] c_in, logic [7:0] b);
            logic [7:0] c;
            logic       fb;
            c = c_in;
            for (int i = 7; i >= 0; i--) begin
                fb = c[7] ^ b[i];
                c  = {c[6:0], 1'b0} ^ (fb ? srcc_pkg::CRC_POLY : 8'h00);
            end
            return c;
        endfunction

        static function logic [7:0] word_crc(logic [15:0] w);
            return crc_update(crc_update(srcc_pkg::CRC_INIT, w[15:8]), w[7:0]);
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void take_byte(logic [7:0] b, logic start);
            logic [2:0]        p;
            srcc_pkg::t_result r;
            p = (start || pos > srcc_pkg::POS_W1_CRC) ? srcc_pkg::POS_W0_HI : pos;
            case (p)
                srcc_pkg::POS_W0_HI: begin
                    crc = crc_update(srcc_pkg::CRC_INIT, b);
                    w0  = {b, 8'h00};
                end
                srcc_pkg::POS_W0_LO: begin
                    crc      = crc_update(crc, b);
                    w0[7:0]  = b;
                end
                srcc_pkg::POS_W0_CRC: begin
                    w0_bad = (crc != b);
                    crc    = srcc_pkg::CRC_INIT;
                end
                srcc_pkg::POS_W1_HI: begin
                    crc = crc_update(srcc_pkg::CRC_INIT, b);
                    w1  = {b, 8'h00};
                end
                srcc_pkg::POS_W1_LO: begin
                    crc      = crc_update(crc, b);
                    w1[7:0]  = b;
                end
                default: begin
                    r.co2_word = w0;
                    r.voc_word = w1;
                    // first word wins when both are bad
                    if (w0_bad) begin
                        r.status = srcc_pkg::STATUS_W0_BAD;
                    end else if (crc != b) begin
                        r.status = srcc_pkg::STATUS_W1_BAD;
                    end else begin
                        r.status = srcc_pkg::STATUS_OK;
                    end
                    expected_replies.push_back(r);
                    crc = srcc_pkg::CRC_INIT;
                end
            endcase
            pos = (p == srcc_pkg::POS_W1_CRC) ? srcc_pkg::POS_W0_HI : p + 3'd1;
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_reply(input logic [39:0] tdata);
            srcc_pkg::t_result got;
            srcc_pkg::t_result want;
            got = srcc_pkg::t_result'(tdata[33:0]);
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf("reply %h with none expected", tdata));
                return;
            end
            want = expected_replies.pop_front();
            if (got.co2_word !== want.co2_word)
                report_mismatch($sformatf("co2_word %h, want %h", got.co2_word, want.co2_word));
            if (got.voc_word !== want.voc_word)
                report_mismatch($sformatf("voc_word %h, want %h", got.voc_word, want.voc_word));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (tdata[39:34] !== 6'd0)
                report_mismatch($sformatf("pad bits %b not zero", tdata[39:34]));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;    // [7:0] rx_byte
    logic        i_s_tuser;    // [0] frame_start
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;    // [15:0] co2_word, [31:16] voc_word, [33:32] status

    reply_tracker tracker;
    int           sent;
    bit           idle_on;
    int           stall_cnt;

    sensor_reply_crc_checker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog on cycles where neither side moves a transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("[sensor_reply_crc_checker] ERROR");
                $finish;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= start;
        do @(posedge i_clk); while (!o_s_tready);
        tracker.take_byte(b, start);
        sent++;
        @(negedge i_clk);
    endtask

    // sends the first nbytes of a frame, optionally with corrupted crc bytes
    task automatic send_frame(input logic [15:0] w0, input logic [15:0] w1,
                              input bit bad0, input bit bad1, input logic start,
                              input int nbytes);
        logic [7:0] fr [6];
        fr[0] = w0[15:8];
        fr[1] = w0[7:0];
        fr[2] = reply_tracker::word_crc(w0) ^ (bad0 ? 8'($urandom_range(1, 255)) : 8'h00);
        fr[3] = w1[15:8];
        fr[4] = w1[7:0];
        fr[5] = reply_tracker::word_crc(w1) ^ (bad1 ? 8'($urandom_range(1, 255)) : 8'h00);
        for (int i = 0; i < nbytes; i++)
            send_byte(fr[i], (i == 0) ? start : 1'b0);
    endtask

    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (tracker.pending() != 0);
    endtask

    initial begin : reply_sink
        int gap;
        bit rx_held;
        rx_held    = 1'b0;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!rx_held && sent >= 400) begin
                // long back-pressure so the block fills and stalls its input
                rx_held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            end
            gap = idle_on ? $urandom_range(0, 15) : 0;
            if (gap != 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            tracker.check_reply(o_m_tdata);
        end
    end

    initial begin : byte_source
        int  kind;
        int  n;
        int  phase;
        int  next_phase;
        bit  aligned;
        bit  drained;
        tracker    = new();
        sent       = 0;
        idle_on    = 1'b1;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = 8'h00;
        i_s_tuser  = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extreme words, each crc outcome, restart mid-frame
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1, 6);
        send_frame(16'h1234, 16'h5678, 1'b1, 1'b0, 1'b0, 6);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b1, 6);
        send_frame(16'hA55A, 16'h0FF0, 1'b0, 1'b0, 1'b1, 2);
        send_frame(16'h8001, 16'h7FFE, 1'b1, 1'b1, 1'b1, 6);
        send_frame(16'h00FF, 16'hFF00, 1'b0, 1'b0, 1'b1, 5);
        send_frame(16'hC3C3, 16'h3C3C, 1'b0, 1'b0, 1'b1, 6);

        aligned    = 1'b1;
        drained    = 1'b0;
        phase      = 0;
        next_phase = sent;
        while (sent < N_ITEMS) begin
            if (sent >= next_phase) begin
                // every third phase runs with no idle cycles on either side
                idle_on    = (phase % 3) != 2;
                phase++;
                next_phase = next_phase + 200;
            end
            if (!drained && sent >= 900) begin
                wait_drain();
                drained = 1'b1;
            end
            kind = $urandom_range(0, 15);
            if (kind <= 10) begin
                send_frame(16'($urandom), 16'($urandom),
                           $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                           aligned ? 1'($urandom_range(0, 1)) : 1'b1, 6);
                aligned = 1'b1;
            end else if (kind <= 12) begin
                send_frame(16'($urandom), 16'($urandom), 1'b0, 1'b0, 1'b1,
                           $urandom_range(1, 5));
                aligned = 1'b0;
            end else begin
                n = $urandom_range(1, 8);
                repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                aligned = 1'b0;
            end
        end

        i_s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.mismatch_count == 0) begin
            $display("[sensor_reply_crc_checker] OK");
        end else begin
            $display("[sensor_reply_crc_checker] ERROR");
        end
        $finish;
    end

endmodule

@@ sensor_reply_crc_checker.f @@
rtl/core/srcc_pkg.sv
rtl/core/srcc_frame_tracker.sv
rtl/core/srcc_out_stage.sv
rtl/core/sensor_reply_crc_checker.sv
sim/tb_top.sv
